@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files.
// Included by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DPD_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: condition must never hold");
`define DPD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");
`else
`define DPD_ASSERT_NEVER(label, clk, rst_n, cond)
`define DPD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/dpd_pkg.sv @@
// Shared types, character codes and helpers for the debug packet deframer.
// No dependencies.
package dpd_pkg;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_TX      = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ACK   = 8'h2B;
  localparam logic [7:0] CH_NAK   = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Record queue depth; a power of two, at least 2.
  localparam int unsigned QUEUE_DEPTH = 4;

  // One queued record: a payload word, or the end of a frame.
  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
    logic       good;
    logic       seq;
    logic [7:0] fc0;
    logic [7:0] fc1;
  } rec_t;

  // {bad, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'h00;
    r = {1'b1, 4'h0};
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b0, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      r = {1'b0, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      r = {1'b0, d[3:0]};
    end
    return r;
  endfunction

endpackage

@@ rtl/dpd_parser.sv @@
// Frame parser: input register, frame state and record generation.
// Depends on dpd_pkg.
module dpd_parser import dpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_take_i,
  input  logic [7:0] rx_byte_i,
  output logic       busy_o,
  output logic       rec_valid_o,
  output rec_t       rec_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_LO   = 2'd3;

  logic       in_valid_q;
  logic [7:0] byte_q;

  logic [1:0] phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic [3:0] hi_q, hi_d;
  logic       bad_q, bad_d;
  logic [1:0] pos_q, pos_d;
  logic [7:0] fc0_q, fc0_d, fc1_q, fc1_d;
  logic       colon_q, colon_d;

  logic [4:0] hex;
  logic       good;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take_i) begin
      byte_q <= rx_byte_i;
    end
  end

  assign hex  = hex_decode(byte_q);
  assign good = !bad_q && !hex[4] && ({hi_q, hex[3:0]} == sum_q);

  always_comb begin
    phase_d     = phase_q;
    sum_d       = sum_q;
    hi_d        = hi_q;
    bad_d       = bad_q;
    pos_d       = pos_q;
    fc0_d       = fc0_q;
    fc1_d       = fc1_q;
    colon_d     = colon_q;
    rec_valid_o = 1'b0;
    rec_o       = '0;
    if (in_valid_q) begin
      case (phase_q)
        PH_IDLE: begin
          if (byte_q == CH_START) begin
            phase_d = PH_BODY;
            sum_d   = 8'h00;
            hi_d    = 4'h0;
            bad_d   = 1'b0;
            pos_d   = 2'd0;
            colon_d = 1'b0;
          end
        end
        PH_BODY: begin
          if (byte_q == CH_HASH) begin
            phase_d = PH_HI;
          end else begin
            sum_d = sum_q + byte_q;
            if (pos_q == 2'd0) begin
              fc0_d = byte_q;
            end else if (pos_q == 2'd1) begin
              fc1_d = byte_q;
            end else if (pos_q == 2'd2 && byte_q == CH_COLON) begin
              colon_d = 1'b1;
            end
            if (pos_q != 2'd3) begin
              pos_d = pos_q + 2'd1;
            end
            rec_valid_o = 1'b1;
            rec_o.data  = byte_q;
          end
        end
        PH_HI: begin
          if (hex[4]) begin
            bad_d = 1'b1;
            hi_d  = 4'h0;
          end else begin
            hi_d = hex[3:0];
          end
          phase_d = PH_LO;
        end
        PH_LO: begin
          rec_valid_o  = 1'b1;
          rec_o.is_end = 1'b1;
          rec_o.good   = good;
          rec_o.seq    = colon_q;
          rec_o.fc0    = fc0_q;
          rec_o.fc1    = fc1_q;
          bad_d        = bad_q | hex[4];
          phase_d      = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      sum_q   <= 8'h00;
      hi_q    <= 4'h0;
      bad_q   <= 1'b0;
      pos_q   <= 2'd0;
      fc0_q   <= 8'h00;
      fc1_q   <= 8'h00;
      colon_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      hi_q    <= hi_d;
      bad_q   <= bad_d;
      pos_q   <= pos_d;
      fc0_q   <= fc0_d;
      fc1_q   <= fc1_d;
      colon_q <= colon_d;
    end
  end

  assign busy_o = in_valid_q;

endmodule

@@ rtl/dpd_out_queue.sv @@
// Record queue and result expander with the output register.
// A frame-end record expands into 2 or 4 result words. Depends on dpd_pkg.
module dpd_out_queue import dpd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  rec_t                         rec_i,
  output logic [$clog2(QUEUE_DEPTH):0] level_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   out_kind_o,
  output logic [7:0]                   out_byte_o,
  output logic                         frame_good_o,
  output logic                         has_sequence_o,
  output logic                         last_o
);

  localparam int unsigned Depth = QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned LvlW  = PtrW + 1;

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [LvlW-1:0] level_q, level_d;
  logic [1:0]      sub_q;

  rec_t       head;
  logic       load;
  logic       pop;
  logic [1:0] n_last;
  logic [1:0] kind;
  logic [7:0] data;
  logic       good;
  logic       seq;
  logic       is_last;

  logic       out_valid_q;
  logic [1:0] kind_q;
  logic [7:0] data_q;
  logic       good_q, seq_q, last_q;

  assign head = mem_q[rd_q];
  assign load = (level_q != '0) && (!out_valid_q || !out_stall_i);

  always_comb begin
    kind = KIND_PAYLOAD;
    data = head.data;
    good = 1'b0;
    seq  = 1'b0;
    if (!head.is_end) begin
      n_last = 2'd0;
    end else begin
      n_last = (head.good && head.seq) ? 2'd3 : 2'd1;
      if (sub_q == n_last) begin
        kind = KIND_STATUS;
        data = 8'h00;
        good = head.good;
        seq  = head.seq;
      end else if (sub_q == 2'd0) begin
        kind = KIND_TX;
        data = head.good ? CH_ACK : CH_NAK;
      end else if (sub_q == 2'd1) begin
        kind = KIND_TX;
        data = head.fc0;
      end else begin
        kind = KIND_TX;
        data = head.fc1;
      end
    end
    is_last = (sub_q == n_last);
  end

  assign pop = load && is_last;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
    if (load) begin
      kind_q <= kind;
      data_q <= data;
      good_q <= good;
      seq_q  <= seq;
      last_q <= is_last;
    end
  end

  always_comb begin
    level_d = level_q;
    if (push_i && !pop) begin
      level_d = level_q + 1'b1;
    end else if (!push_i && pop) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q        <= '0;
      rd_q        <= '0;
      level_q     <= '0;
      sub_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      level_q <= level_d;
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q  <= rd_q + 1'b1;
        sub_q <= 2'd0;
      end else if (load) begin
        sub_q <= sub_q + 2'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign level_o        = level_q;
  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = kind_q;
  assign out_byte_o     = data_q;
  assign frame_good_o   = good_q;
  assign has_sequence_o = seq_q;
  assign last_o         = last_q;

endmodule

@@ rtl/debug_packet_deframer.sv @@
// Debug packet deframer top level: '$' body '#' hh framing with checksum check.
// Depends on dpd_pkg, dpd_parser, dpd_out_queue and assert_macros.svh.
//
// Input channel: in_valid_i / in_stall_o carry one received word (rx_byte_i).
// Output channel: out_valid_o / out_stall_i carry one result word: out_kind_o
// (payload, transmit or status), out_byte_o, frame_good_o, has_sequence_o and
// last_o, which marks the final result caused by one input word.
// A word is registered on acceptance and parsed in the next cycle; its record
// enters a QUEUE_DEPTH-entry queue and moves on to the output register once
// that register is empty or not stalled. Input throughput is one word per
// cycle while in_stall_o is low. The output register emits one result per
// cycle while out_stall_i is low; a frame end expands into 2 or 4 results
// ('+'/'-', the echoed sequence id, status), and the queue absorbs that
// burst. in_stall_o rises when queued records plus the word under parse fill
// the queue. A stalled output holds its word and the queue fills behind it.
// Reset empties the queue, clears the output valid flag and returns the parser
// to idle, where everything before '$' is dropped.
`include "assert_macros.svh"
module debug_packet_deframer import dpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       frame_good_o,
  output logic       has_sequence_o,
  output logic       last_o
);

  localparam int unsigned LvlW = $clog2(QUEUE_DEPTH) + 1;

  logic            busy;
  logic            rec_valid;
  rec_t            rec;
  logic [LvlW-1:0] level;
  logic [LvlW:0]   pending;
  logic            in_take;

  assign pending    = {1'b0, level} + {{LvlW{1'b0}}, busy};
  assign in_stall_o = (pending >= (LvlW+1)'(QUEUE_DEPTH));
  assign in_take    = in_valid_i && !in_stall_o;

  dpd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_take_i   (in_take),
    .rx_byte_i   (rx_byte_i),
    .busy_o      (busy),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  dpd_out_queue u_out_queue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (rec_valid),
    .rec_i          (rec),
    .level_o        (level),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_kind_o     (out_kind_o),
    .out_byte_o     (out_byte_o),
    .frame_good_o   (frame_good_o),
    .has_sequence_o (has_sequence_o),
    .last_o         (last_o)
  );

  `DPD_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, rec_valid && (level == (LvlW)'(QUEUE_DEPTH)))
  `DPD_ASSERT_IMPLIES(a_payload_last, clk_i, rst_ni, out_valid_o && (out_kind_o == KIND_PAYLOAD), last_o && !frame_good_o && !has_sequence_o)
  `DPD_ASSERT_IMPLIES(a_status_form, clk_i, rst_ni, out_valid_o && (out_kind_o == KIND_STATUS), last_o && (out_byte_o == 8'h00))
  `DPD_ASSERT_IMPLIES(a_tx_not_last, clk_i, rst_ni, out_valid_o && (out_kind_o == KIND_TX), !last_o)

endmodule
